// File: rtl/irsa_pkg.sv
// ----------------------------------------------------------------------------
// IR relay selector / attenuator controller package
// Shared types, key codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package irsa_pkg;

  localparam int NumChannels = 4;
  localparam int ChanW       = 2;
  localparam int AttBits     = 6;
  localparam int CntW        = 4;   // holds two passes over the relay bits
  localparam int IdxW        = 3;

  localparam logic [AttBits-1:0] AttMax = '1;

  // key codes
  localparam logic [3:0] KeyNone   = 4'd0;
  localparam logic [3:0] KeyChUp   = 4'd1;
  localparam logic [3:0] KeyChDown = 4'd2;
  localparam logic [3:0] KeyVolUp  = 4'd3;
  localparam logic [3:0] KeyVolDn  = 4'd4;
  localparam logic [3:0] KeyOk     = 4'd5;
  localparam logic [3:0] KeyCh1    = 4'd6;
  localparam logic [3:0] KeyCh2    = 4'd7;
  localparam logic [3:0] KeyCh3    = 4'd8;
  localparam logic [3:0] KeyCh4    = 4'd9;

  // configuration register indexes
  localparam logic [3:0] RegProtocol   = 4'd0;
  localparam logic [3:0] RegAddress    = 4'd1;
  localparam logic [3:0] RegSwitchOrd  = 4'd2;
  localparam logic [3:0] RegStartChan  = 4'd3;

  localparam logic TargetChan  = 1'b0;
  localparam logic TargetAtten = 1'b1;

  typedef struct packed {
    logic [7:0]  frame_protocol;
    logic [15:0] frame_address;
    logic [3:0]  key;
    logic        repeat_req;
  } in_req_t;

  typedef struct packed {
    logic        target;
    logic [5:0]  port_value;
    logic        settle_wait;
    logic        last;
  } out_res_t;

endpackage

`default_nettype wire

// File: rtl/ir_relay_selector_attenuator_ctrl.sv
// Throughput: the relay scan walks one relay bit per cycle while the output is free, and
// the next request is taken only once the sequence for the last one has ended.
// Reset: asynchronous, all attenuator relays set, all stored attenuations at
// maximum, start channel applied on the first request.
// ----------------------------------------------------------------------------
// IR relay selector / attenuator controller
// Decodes remote keys into channel and attenuation changes and sequences the
// relay port writes through one shared output register, stepping attenuation bit by bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_relay_selector_attenuator_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [3:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire irsa_pkg::in_req_t  in_req_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      irsa_pkg::out_res_t out_res_o
);

  typedef enum logic [2:0] {
    StIdle, StDecode, StMute, StLoad, StSelect, StScan
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [7:0]                  protocol_q;
  logic [15:0]                 address_q;
  logic                        switch_ord_q;
  logic [irsa_pkg::ChanW-1:0]  start_chan_q;

  // block state
  irsa_pkg::in_req_t           req_q;
  logic [irsa_pkg::ChanW-1:0]  cur_chan_q, cur_chan_d;
  logic [irsa_pkg::ChanW-1:0]  applied_chan_q, applied_chan_d;
  logic                        applied_valid_q, applied_valid_d;
  logic [irsa_pkg::AttBits-1:0] cur_att_q, cur_att_d;
  logic [irsa_pkg::AttBits-1:0] att_port_q, att_port_d;
  logic [irsa_pkg::AttBits-1:0] att_mem_q [irsa_pkg::NumChannels];
  logic                        mem_we;
  logic [irsa_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        dir_up_q, dir_up_d;

  logic                        out_valid_q, out_valid_d;
  irsa_pkg::out_res_t          out_q, out_d;
  logic                        out_free;
  logic                        emit;

  // decode
  logic [irsa_pkg::ChanW-1:0]   ch_base, ch_new;
  logic [irsa_pkg::AttBits-1:0] at_inc, at_dec, at_new;
  logic                         frame_match;

  // scan unit
  logic                         pass2;
  logic [irsa_pkg::IdxW-1:0]    bit_idx;
  logic                         bit_diff;
  logic                         bit_val;
  logic [irsa_pkg::AttBits-1:0] port_new;
  logic                         scan_end;
  logic [irsa_pkg::NumChannels-1:0] chan_onehot;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    ch_base     = applied_valid_q ? cur_chan_q : start_chan_q;
    frame_match = (req_q.frame_protocol == protocol_q) &&
                  (req_q.frame_address == address_q);
    at_inc      = (cur_att_q == irsa_pkg::AttMax) ? cur_att_q : cur_att_q + 1'b1;
    at_dec      = (cur_att_q == '0) ? cur_att_q : cur_att_q - 1'b1;
    ch_new      = ch_base;
    at_new      = cur_att_q;
    if (frame_match) begin
      case (req_q.key) inside
        irsa_pkg::KeyVolUp: at_new = at_dec;
        irsa_pkg::KeyVolDn: at_new = at_inc;
        irsa_pkg::KeyChUp: begin
          if (!req_q.repeat_req) ch_new = ch_base + 1'b1;
        end
        irsa_pkg::KeyChDown: begin
          if (!req_q.repeat_req) ch_new = ch_base - 1'b1;
        end
        [irsa_pkg::KeyCh1:irsa_pkg::KeyCh4]: begin
          if (!req_q.repeat_req) begin
            ch_new = irsa_pkg::ChanW'(req_q.key - irsa_pkg::KeyCh1);
          end
        end
        default: ;
      endcase
    end
  end

  // one relay bit per step: index from pass and direction
  always_comb begin
    pass2 = 1'b0;
    if (switch_ord_q) begin
      pass2   = (cnt_q >= irsa_pkg::CntW'(irsa_pkg::AttBits));
      bit_idx = pass2 ? irsa_pkg::IdxW'(cnt_q - irsa_pkg::CntW'(irsa_pkg::AttBits))
                      : irsa_pkg::IdxW'(cnt_q);
    end else if (dir_up_q) begin
      bit_idx = irsa_pkg::IdxW'(cnt_q);
    end else begin
      bit_idx = irsa_pkg::IdxW'(irsa_pkg::CntW'(irsa_pkg::AttBits - 1) - cnt_q);
    end
    bit_diff = att_port_q[bit_idx] != cur_att_q[bit_idx];
    // first make-before-break pass only makes; a break just waits
    bit_val  = (switch_ord_q && !pass2 && !cur_att_q[bit_idx]) ? att_port_q[bit_idx]
                                                                : cur_att_q[bit_idx];
    port_new = att_port_q;
    port_new[bit_idx] = bit_val;
    scan_end = (port_new == cur_att_q);
  end

  assign chan_onehot = irsa_pkg::NumChannels'(1) << cur_chan_q;

  always_comb begin
    state_d         = state_q;
    cur_chan_d      = cur_chan_q;
    applied_chan_d  = applied_chan_q;
    applied_valid_d = applied_valid_q;
    cur_att_d       = cur_att_q;
    att_port_d      = att_port_q;
    cnt_d           = cnt_q;
    dir_up_d        = dir_up_q;
    mem_we          = 1'b0;
    emit            = 1'b0;
    out_d           = out_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StDecode;
      end
      StDecode: begin
        cur_chan_d = ch_new;
        cur_att_d  = at_new;
        cnt_d      = '0;
        dir_up_d   = at_new < att_port_q;
        if (!applied_valid_q || ch_new != applied_chan_q) begin
          mem_we  = applied_valid_q;
          state_d = StMute;
        end else if (at_new != att_port_q) begin
          state_d = StScan;
        end else begin
          state_d = StIdle;
        end
      end
      StMute: begin
        if (out_free) begin
          emit    = 1'b1;
          out_d   = '{target: irsa_pkg::TargetChan, port_value: '0,
                      settle_wait: 1'b1, last: 1'b0};
          state_d = StLoad;
        end
      end
      StLoad: begin
        if (out_free) begin
          emit       = 1'b1;
          cur_att_d  = att_mem_q[cur_chan_q];
          att_port_d = att_mem_q[cur_chan_q];
          out_d      = '{target: irsa_pkg::TargetAtten,
                         port_value: 6'(att_mem_q[cur_chan_q]),
                         settle_wait: 1'b0, last: 1'b0};
          state_d    = StSelect;
        end
      end
      StSelect: begin
        if (out_free) begin
          emit            = 1'b1;
          applied_chan_d  = cur_chan_q;
          applied_valid_d = 1'b1;
          out_d           = '{target: irsa_pkg::TargetChan,
                              port_value: 6'(chan_onehot),
                              settle_wait: 1'b1, last: 1'b1};
          state_d         = StIdle;
        end
      end
      StScan: begin
        if (!bit_diff) begin
          cnt_d = cnt_q + 1'b1;
        end else if (out_free) begin
          emit       = 1'b1;
          att_port_d = port_new;
          cnt_d      = cnt_q + 1'b1;
          out_d      = '{target: irsa_pkg::TargetAtten, port_value: 6'(port_new),
                         settle_wait: 1'b1, last: scan_end};
          if (scan_end) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    out_valid_d = emit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      protocol_q      <= '0;
      address_q       <= '0;
      switch_ord_q    <= 1'b0;
      start_chan_q    <= '0;
      cur_chan_q      <= '0;
      applied_chan_q  <= '0;
      applied_valid_q <= 1'b0;
      cur_att_q       <= irsa_pkg::AttMax;
      att_port_q      <= irsa_pkg::AttMax;
      for (int i = 0; i < irsa_pkg::NumChannels; i++) begin
        att_mem_q[i] <= irsa_pkg::AttMax;
      end
      cnt_q           <= '0;
      dir_up_q        <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      cur_chan_q      <= cur_chan_d;
      applied_chan_q  <= applied_chan_d;
      applied_valid_q <= applied_valid_d;
      cur_att_q       <= cur_att_d;
      att_port_q      <= att_port_d;
      cnt_q           <= cnt_d;
      dir_up_q        <= dir_up_d;
      out_valid_q     <= out_valid_d;
      // save the attenuation of the channel being left
      if (mem_we) att_mem_q[applied_chan_q] <= cur_att_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          irsa_pkg::RegProtocol:  protocol_q   <= cfg_data_i[7:0];
          irsa_pkg::RegAddress:   address_q    <= cfg_data_i;
          irsa_pkg::RegSwitchOrd: switch_ord_q <= cfg_data_i[0];
          irsa_pkg::RegStartChan: start_chan_q <= cfg_data_i[irsa_pkg::ChanW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) req_q <= in_req_i;
    out_q <= out_d;
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while sequencer idle next cycle");

  a_applied_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    applied_valid_q |=> applied_valid_q)
    else $error("applied channel flag dropped");

  a_scan_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (att_port_q != cur_att_q))
    else $error("relay scan running with port already at goal");

endmodule

`default_nettype wire

// File: tb/relay_write_checker.sv
// ----------------------------------------------------------------------------
// Relay write checker
// Watches the register, request and result channels of the IR relay
// selector/attenuator controller. Keeps its own copy of the registers and of
// the channel and attenuation state, works out the relay port writes that
// each accepted request must cause, and compares every accepted result with
// the oldest write still due.
// ----------------------------------------------------------------------------

module relay_write_checker
  import irsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_req_t     in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_res_t    out_res_i,
  output int          mismatch_count_o,
  output int          writes_due_o
);

  // register copies
  logic [7:0]         proto_id;
  logic [15:0]        remote_addr;
  logic               make_first;
  logic [ChanW-1:0]   start_chan;

  // selector / attenuator state
  logic [ChanW-1:0]   sel_chan;
  logic [ChanW-1:0]   live_chan;
  logic               live_ok;
  logic [AttBits-1:0] att_level;
  logic [AttBits-1:0] att_live;
  logic [AttBits-1:0] att_port;
  logic [AttBits-1:0] att_saved [NumChannels];

  out_res_t relay_writes_due [$];
  out_res_t step_writes [$];
  out_res_t want;

  function automatic void note_write(logic target, logic [AttBits-1:0] value, logic settle);
    out_res_t w;
    w.target      = target;
    w.port_value  = value;
    w.settle_wait = settle;
    w.last        = 1'b0;
    step_writes.push_back(w);
  endfunction

  function automatic void predict_relay_writes(in_req_t req);
    int                   ch;
    int                   at;
    int                   i;
    int                   b;
    logic                 up;
    logic [AttBits-1:0]   goal;
    logic [NumChannels-1:0] onehot;
    out_res_t             w;
    step_writes.delete();
    // first request after reset picks up the start channel
    if (!live_ok) sel_chan = (int'(start_chan) < NumChannels) ? start_chan : '0;
    ch = int'(sel_chan);
    at = int'(att_level);
    if (req.frame_protocol == proto_id && req.frame_address == remote_addr) begin
      if (!req.repeat_req) begin
        case (req.key) inside
          KeyChUp:   ch = ch + 1;
          KeyChDown: ch = ch - 1;
          KeyVolUp:  at = at - 1;
          KeyVolDn:  at = at + 1;
          [KeyCh1:KeyCh4]: ch = int'(req.key) - int'(KeyCh1);
          default: ;
        endcase
      end else if (req.key == KeyVolUp) begin
        at = at - 1;
      end else if (req.key == KeyVolDn) begin
        at = at + 1;
      end
      if (ch > NumChannels - 1) ch = 0;
      else if (ch < 0) ch = NumChannels - 1;
      sel_chan = ch[ChanW-1:0];
      if (at > int'(AttMax)) at = int'(AttMax);
      else if (at < 0) at = 0;
      att_level = at[AttBits-1:0];
    end

    // channel change: save, mute, restore, select
    if (!live_ok || sel_chan != live_chan) begin
      if (live_ok) att_saved[live_chan] = att_level;
      note_write(TargetChan, '0, 1'b1);
      att_level = att_saved[sel_chan];
      att_live  = att_level;
      att_port  = att_level;
      note_write(TargetAtten, att_port, 1'b0);
      onehot = '0;
      onehot[sel_chan] = 1'b1;
      note_write(TargetChan, AttBits'(onehot), 1'b1);
      live_chan = sel_chan;
      live_ok   = 1'b1;
    end

    // attenuation change: at most one relay per write
    if (att_level != att_live && att_port != att_level) begin
      goal = att_level;
      if (!make_first) begin
        up = att_level < att_live;
        for (i = 0; i < AttBits; i++) begin
          b = up ? i : AttBits - 1 - i;
          if (att_port[b] != goal[b]) begin
            att_port[b] = goal[b];
            note_write(TargetAtten, att_port, 1'b1);
          end
        end
      end else begin
        // set pass first; relays to clear only get a settle slot here
        for (i = 0; i < AttBits; i++) begin
          if (att_port[i] != goal[i]) begin
            if (goal[i]) att_port[i] = 1'b1;
            note_write(TargetAtten, att_port, 1'b1);
          end
        end
        for (i = 0; i < AttBits; i++) begin
          if (att_port[i] != goal[i]) begin
            att_port[i] = 1'b0;
            note_write(TargetAtten, att_port, 1'b1);
          end
        end
      end
      att_live = att_level;
    end

    for (i = 0; i < step_writes.size(); i++) begin
      w = step_writes[i];
      w.last = (i == step_writes.size() - 1);
      relay_writes_due.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_id    = '0;
      remote_addr = '0;
      make_first  = 1'b0;
      start_chan  = '0;
      sel_chan    = '0;
      live_chan   = '0;
      live_ok     = 1'b0;
      att_level   = AttMax;
      att_live    = AttMax;
      att_port    = AttMax;
      for (int c = 0; c < NumChannels; c++) att_saved[c] = AttMax;
      relay_writes_due.delete();
      mismatch_count_o = 0;
      writes_due_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegProtocol:  proto_id    = cfg_data_i[7:0];
          RegAddress:   remote_addr = cfg_data_i;
          RegSwitchOrd: make_first  = cfg_data_i[0];
          RegStartChan: start_chan  = cfg_data_i[ChanW-1:0];
          default: ;
        endcase
      end

      // results seen at this edge belong to earlier requests: check first
      if (out_valid_i && !out_stall_i) begin
        if (relay_writes_due.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("unexpected relay write: target %0d value %02h settle %0d last %0d",
                     out_res_i.target, out_res_i.port_value, out_res_i.settle_wait,
                     out_res_i.last);
        end else begin
          want = relay_writes_due.pop_front();
          if (out_res_i.target !== want.target || out_res_i.port_value !== want.port_value ||
              out_res_i.settle_wait !== want.settle_wait || out_res_i.last !== want.last) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("relay write mismatch: expected %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
                       want.target, want.port_value, want.settle_wait, want.last,
                       out_res_i.target, out_res_i.port_value, out_res_i.settle_wait,
                       out_res_i.last);
          end
        end
      end

      if (in_valid_i && !in_stall_i) predict_relay_writes(in_req_i);
      writes_due_o = relay_writes_due.size();
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// IR relay selector / attenuator testbench
// Drives decoded IR frames and register writes into the controller with
// random gaps and output stalls: a directed set of keys and corner cases
// first, then random key sequences under several register settings. The
// relay write checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------

module tb;
  import irsa_pkg::*;

  localparam int         IdleLimit = 2000;
  localparam logic [3:0] KeyBeyond = 4'd15;   // past the last defined key

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_req_t     in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_res_t    out_res_o;

  int          mismatches;
  int          writes_due;
  logic        calm;
  logic [7:0]  match_proto;
  logic [15:0] match_addr;

  ir_relay_selector_attenuator_ctrl uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  relay_write_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_req_i         (in_req_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_res_i        (out_res_o),
    .mismatch_count_o (mismatches),
    .writes_due_o     (writes_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // end the run once no channel has moved for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i))
        idle = 0;
      else
        idle++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // result side: stall a random number of cycles before each result
  initial begin : result_stall
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  function automatic in_req_t keyed_frame(logic [3:0] key, logic rep);
    in_req_t f;
    f.frame_protocol = match_proto;
    f.frame_address  = match_addr;
    f.key            = key;
    f.repeat_req     = rep;
    return f;
  endfunction

  // hold valid across back-to-back requests; drop it only for a gap
  task automatic send_frame(input in_req_t f);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req_i   <= f;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // wait until every due write has come out and the sequencer is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (writes_due != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] proto, input logic [15:0] addr,
                              input logic order, input logic [1:0] start);
    logic [3:0]  idx [4];
    logic [15:0] val [4];
    int          r;
    idx = '{RegProtocol, RegAddress, RegSwitchOrd, RegStartChan};
    val = '{{8'h00, proto}, addr, {15'h0000, order}, {14'h0000, start}};
    match_proto = proto;
    match_addr  = addr;
    for (r = 0; r < 4; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[r];
      cfg_data_i  <= val[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    in_req_t    f;
    logic [3:0] key;
    int         phase;
    int         sent;
    int         pick;
    int         run;
    int         j;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    calm        = 1'b0;
    match_proto = '0;
    match_addr  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: direction-ordered switching, start on the last channel
    program_regs(8'h00, 16'h0000, 1'b0, 2'd3);
    f = keyed_frame(KeyChUp, 1'b0);
    f.frame_protocol = 8'h5A;        // foreign frame still applies the start channel
    send_frame(f);
    send_frame(keyed_frame(KeyVolUp, 1'b0));
    send_frame(keyed_frame(KeyVolUp, 1'b1));
    send_frame(keyed_frame(KeyVolDn, 1'b0));
    send_frame(keyed_frame(KeyVolDn, 1'b1));
    send_frame(keyed_frame(KeyVolDn, 1'b0));   // clamp at full attenuation
    send_frame(keyed_frame(KeyNone, 1'b0));
    send_frame(keyed_frame(KeyOk, 1'b0));
    send_frame(keyed_frame(KeyBeyond, 1'b1));
    send_frame(keyed_frame(KeyVolUp, 1'b0));
    send_frame(keyed_frame(KeyChUp, 1'b0));    // wrap past the last channel
    send_frame(keyed_frame(KeyChDown, 1'b0));  // wrap below the first channel
    send_frame(keyed_frame(KeyCh1, 1'b0));
    send_frame(keyed_frame(KeyCh4, 1'b1));     // channel keys ignore repeats
    send_frame(keyed_frame(KeyCh2, 1'b0));
    send_frame(keyed_frame(KeyCh3, 1'b0));
    send_frame(keyed_frame(KeyCh4, 1'b0));
    f = keyed_frame(KeyVolUp, 1'b0);
    f.frame_address = 16'h8001;
    send_frame(f);
    f = keyed_frame(KeyChUp, 1'b0);
    f.frame_protocol = 8'h80;
    send_frame(f);
    drain();

    // directed: make-before-break at the top of the register ranges
    program_regs(8'hFF, 16'hFFFF, 1'b1, 2'd0);
    send_frame(keyed_frame(KeyVolUp, 1'b0));
    send_frame(keyed_frame(KeyVolDn, 1'b1));
    send_frame(keyed_frame(KeyVolUp, 1'b1));
    send_frame(keyed_frame(KeyChUp, 1'b0));
    send_frame(keyed_frame(KeyNone, 1'b1));

    // random key sequences under changing settings
    for (phase = 0; phase < 8; phase++) begin
      drain();
      program_regs((phase == 2) ? 8'h00 : (phase == 5) ? 8'hFF : 8'($urandom),
                   (phase == 2) ? 16'hFFFF : (phase == 5) ? 16'h0000 : 16'($urandom),
                   phase[0], 2'($urandom_range(0, 3)));
      calm = (phase % 3 == 2);
      sent = 0;
      while (sent < 46) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          // volume run: a press, then mostly held repeats
          key = $urandom_range(0, 1) ? KeyVolUp : KeyVolDn;
          run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
          for (j = 0; j < run; j++)
            send_frame(keyed_frame(key, j != 0 && $urandom_range(0, 3) != 0));
          sent += run;
        end else if (pick < 7) begin
          if ($urandom_range(0, 2) == 0)
            key = KeyCh1 + 4'($urandom_range(0, 3));
          else
            key = $urandom_range(0, 1) ? KeyChUp : KeyChDown;
          send_frame(keyed_frame(key, $urandom_range(0, 4) == 0));
          sent++;
        end else if (pick == 7) begin
          send_frame(keyed_frame(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          sent++;
        end else begin
          // noise: wrong protocol, wrong address or both
          f = keyed_frame(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
          case ($urandom_range(0, 2))
            0: f.frame_protocol = 8'($urandom);
            1: f.frame_address = 16'($urandom);
            default: begin
              f.frame_protocol = 8'($urandom);
              f.frame_address  = 16'($urandom);
            end
          endcase
          send_frame(f);
          sent++;
        end
      end
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
